/* design/imbe_pkg.sv */
// ============================================================================
// imbe_pkg - shared types and constants of the I2C master byte engine
// Command codes, phase encoding and beat field widths.
// ============================================================================
package imbe_pkg;

  // Command codes carried in the func field of an input beat
  localparam logic [2:0] FUNC_TICK  = 3'd0;
  localparam logic [2:0] FUNC_START = 3'd1;
  localparam logic [2:0] FUNC_STOP  = 3'd2;
  localparam logic [2:0] FUNC_WRITE = 3'd3;
  localparam logic [2:0] FUNC_READ  = 3'd4;

  // Configuration register indexes
  localparam logic CFG_HALF_PERIOD = 1'b0;
  localparam logic CFG_ACK_TIMEOUT = 1'b1;

  // Reset values of the configuration registers
  localparam logic [15:0] HALF_PERIOD_RST = 16'd200;
  localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_DATA_W = 16;

  // Bus sequencing phases, one-hot
  typedef enum logic [13:0] {
    PH_IDLE = 14'b00000000000001,
    PH_S1   = 14'b00000000000010,
    PH_S2   = 14'b00000000000100,
    PH_P1   = 14'b00000000001000,
    PH_P2   = 14'b00000000010000,
    PH_WH   = 14'b00000000100000,
    PH_WL   = 14'b00000001000000,
    PH_A1   = 14'b00000010000000,
    PH_A2   = 14'b00000100000000,
    PH_POLL = 14'b00001000000000,
    PH_RL   = 14'b00010000000000,
    PH_RH   = 14'b00100000000000,
    PH_M1   = 14'b01000000000000,
    PH_M2   = 14'b10000000000000
  } phase_t;

  // Fields of one result beat
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       timed_out;
    logic       ack_seen;
    logic       done_res;
    logic       busy_res;
    logic       sda_released;
    logic       sda_level;
    logic       scl_level;
  } result_t;

endpackage

/* design/i2c_master_byte_engine_unit.sv */
// ============================================================================
// i2c_master_byte_engine_unit - byte-level I2C master sequencer
// Start, stop, write-byte and read-byte commands advanced by tick beats.
// ============================================================================
// Usage:
//   Input stream (in_*): each beat is a command or a tick. While idle the
//   engine takes one command (start, stop, write byte, read byte); while
//   busy it ignores commands and advances only on tick beats, each of which
//   carries the sampled SDA level. Every bus delay lasts half_period_ticks
//   ticks; the acknowledge poll after a write takes one sample per tick.
//   Result stream (out_*): exactly one beat per input beat, giving the SCL
//   and SDA drive after that step plus busy/done and the last write/read
//   outcome (ack_seen, timed_out, rx_byte).
//   The result is registered, valid in the cycle after the input handshake;
//   throughput is one beat per cycle unless stalled, set by the single
//   result register. A stalled receiver holds the result register and
//   backpressures in_tready only while it is full and not being drained.
//   Configuration (cfg_*): single-cycle writes, meant only while idle.
//   Reset (rst_n low, synchronous): phase idle, SCL and SDA driven high,
//   counters and flags cleared, registers back to 200 / 250, no result
//   pending.
// ============================================================================
module i2c_master_byte_engine_unit #(
  parameter int TICK_COUNTER_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [2:0] func, [10:3] tx_byte, [11] ack_after_read, [12] sda_sample, [15:13] zero
  input  logic [imbe_pkg::IN_DATA_W-1:0]   in_tdata,
  // Result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] scl_level, [1] sda_level, [2] sda_released, [3] busy_res, [4] done_res,
  // [5] ack_seen, [6] timed_out, [14:7] rx_byte, [15] zero
  output logic [imbe_pkg::OUT_DATA_W-1:0]  out_tdata,
  // Configuration write port
  input  logic                             cfg_we,
  input  logic                             cfg_addr,
  input  logic [imbe_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int TW = TICK_COUNTER_WIDTH;
  // Compare width covers both the 16-bit period and the tick counter, plus carry
  localparam int CW = ((TW > 16) ? TW : 16) + 1;

  // Configuration registers
  logic [15:0] half_period_r;
  logic [7:0]  ack_timeout_r;

  // Engine state
  imbe_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]    bit_count_r, bit_count_nxt;
  logic [7:0]    shift_r, shift_nxt;
  logic [TW-1:0] tick_count_r, tick_count_nxt;
  logic [7:0]    poll_count_r, poll_count_nxt;
  logic          scl_r, scl_nxt;
  logic          sda_r, sda_nxt;
  logic          sda_in_mode_r, sda_in_mode_nxt;
  logic          ack_choice_r, ack_choice_nxt;
  logic          ack_result_r, ack_result_nxt;
  logic          timeout_flag_r, timeout_flag_nxt;
  logic [7:0]    rx_hold_r, rx_hold_nxt;
  logic          done;

  // Result register
  logic                            out_valid_r;
  logic [imbe_pkg::OUT_DATA_W-1:0] out_data_r;
  imbe_pkg::result_t               res;

  // Input beat fields
  logic [2:0] in_func;
  logic [7:0] in_tx_byte;
  logic       in_ack_after_read;
  logic       in_sda_sample;
  logic       in_accept;

  assign in_func           = in_tdata[2:0];
  assign in_tx_byte        = in_tdata[10:3];
  assign in_ack_after_read = in_tdata[11];
  assign in_sda_sample     = in_tdata[12];

  // Take a new beat whenever the result register is free or draining
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  // Delay timer: the delay expires once tick_count + 1 reaches the period,
  // the period being at least one and at most the counter's full scale.
  logic [CW-1:0] lim_w, period_raw, period_w, next_w;
  logic          expired;

  assign lim_w      = {{(CW-TW){1'b0}}, {TW{1'b1}}};
  assign period_raw = (half_period_r == '0) ? CW'(1) : CW'(half_period_r);
  assign period_w   = (period_raw > lim_w) ? lim_w : period_raw;
  assign next_w     = CW'(tick_count_r) + CW'(1);
  assign expired    = next_w >= period_w;

  // Acknowledge poll limit check
  logic       poll_over;
  logic [8:0] poll_inc;
  assign poll_inc  = {1'b0, poll_count_r} + 9'd1;
  assign poll_over = poll_inc > {1'b0, ack_timeout_r};

  logic [3:0] bit_inc;
  assign bit_inc = bit_count_r + 4'd1;

  always_comb begin
    phase_nxt        = phase_r;
    bit_count_nxt    = bit_count_r;
    shift_nxt        = shift_r;
    tick_count_nxt   = tick_count_r;
    poll_count_nxt   = poll_count_r;
    scl_nxt          = scl_r;
    sda_nxt          = sda_r;
    sda_in_mode_nxt  = sda_in_mode_r;
    ack_choice_nxt   = ack_choice_r;
    ack_result_nxt   = ack_result_r;
    timeout_flag_nxt = timeout_flag_r;
    rx_hold_nxt      = rx_hold_r;
    done             = 1'b0;

    if (in_func == imbe_pkg::FUNC_TICK) begin
      if (phase_r == imbe_pkg::PH_POLL) begin
        // One acknowledge sample per tick, no delay timer
        if (!in_sda_sample) begin
          scl_nxt        = 1'b0;
          ack_result_nxt = 1'b1;
          phase_nxt      = imbe_pkg::PH_IDLE;
          done           = 1'b1;
        end else if (poll_over) begin
          // Give up: flag the timeout and run a stop
          ack_result_nxt   = 1'b0;
          timeout_flag_nxt = 1'b1;
          sda_in_mode_nxt  = 1'b0;
          scl_nxt          = 1'b1;
          sda_nxt          = 1'b0;
          tick_count_nxt   = '0;
          phase_nxt        = imbe_pkg::PH_P1;
        end else begin
          poll_count_nxt = poll_inc[7:0];
        end
      end else if (phase_r != imbe_pkg::PH_IDLE) begin
        if (!expired) begin
          tick_count_nxt = next_w[TW-1:0];
        end else begin
          tick_count_nxt = '0;
          case (phase_r)
            imbe_pkg::PH_S1: begin
              sda_nxt   = 1'b0;
              phase_nxt = imbe_pkg::PH_S2;
            end
            imbe_pkg::PH_S2: begin
              scl_nxt   = 1'b0;
              phase_nxt = imbe_pkg::PH_IDLE;
              done      = 1'b1;
            end
            imbe_pkg::PH_P1: begin
              sda_nxt   = 1'b1;
              phase_nxt = imbe_pkg::PH_P2;
            end
            imbe_pkg::PH_P2: begin
              phase_nxt = imbe_pkg::PH_IDLE;
              done      = 1'b1;
            end
            imbe_pkg::PH_WH: begin
              scl_nxt   = 1'b0;
              phase_nxt = imbe_pkg::PH_WL;
            end
            imbe_pkg::PH_WL: begin
              bit_count_nxt = bit_inc;
              if (bit_inc >= 4'd8) begin
                // Release SDA for the acknowledge
                sda_nxt         = 1'b1;
                sda_in_mode_nxt = 1'b1;
                phase_nxt       = imbe_pkg::PH_A1;
              end else begin
                sda_nxt   = shift_r[7];
                shift_nxt = {shift_r[6:0], 1'b0};
                scl_nxt   = 1'b1;
                phase_nxt = imbe_pkg::PH_WH;
              end
            end
            imbe_pkg::PH_A1: begin
              scl_nxt   = 1'b1;
              phase_nxt = imbe_pkg::PH_A2;
            end
            imbe_pkg::PH_A2: begin
              poll_count_nxt = '0;
              phase_nxt      = imbe_pkg::PH_POLL;
            end
            imbe_pkg::PH_RL: begin
              // Raise SCL and sample the data bit
              scl_nxt   = 1'b1;
              shift_nxt = {shift_r[6:0], in_sda_sample};
              phase_nxt = imbe_pkg::PH_RH;
            end
            imbe_pkg::PH_RH: begin
              bit_count_nxt = bit_inc;
              scl_nxt       = 1'b0;
              if (bit_inc >= 4'd8) begin
                rx_hold_nxt     = shift_r;
                sda_in_mode_nxt = 1'b0;
                sda_nxt         = !ack_choice_r;
                phase_nxt       = imbe_pkg::PH_M1;
              end else begin
                phase_nxt = imbe_pkg::PH_RL;
              end
            end
            imbe_pkg::PH_M1: begin
              scl_nxt   = 1'b1;
              phase_nxt = imbe_pkg::PH_M2;
            end
            imbe_pkg::PH_M2: begin
              scl_nxt   = 1'b0;
              phase_nxt = imbe_pkg::PH_IDLE;
              done      = 1'b1;
            end
            default: begin
              phase_nxt = imbe_pkg::PH_IDLE;
            end
          endcase
        end
      end
    end else if (phase_r == imbe_pkg::PH_IDLE) begin
      // Command while idle; unused codes only clear the timer
      tick_count_nxt = '0;
      case (in_func)
        imbe_pkg::FUNC_START: begin
          sda_in_mode_nxt = 1'b0;
          sda_nxt         = 1'b1;
          scl_nxt         = 1'b1;
          phase_nxt       = imbe_pkg::PH_S1;
        end
        imbe_pkg::FUNC_STOP: begin
          sda_in_mode_nxt = 1'b0;
          scl_nxt         = 1'b1;
          sda_nxt         = 1'b0;
          phase_nxt       = imbe_pkg::PH_P1;
        end
        imbe_pkg::FUNC_WRITE: begin
          ack_result_nxt   = 1'b0;
          timeout_flag_nxt = 1'b0;
          sda_in_mode_nxt  = 1'b0;
          bit_count_nxt    = '0;
          sda_nxt          = in_tx_byte[7];
          shift_nxt        = {in_tx_byte[6:0], 1'b0};
          scl_nxt          = 1'b1;
          phase_nxt        = imbe_pkg::PH_WH;
        end
        imbe_pkg::FUNC_READ: begin
          sda_in_mode_nxt = 1'b1;
          ack_choice_nxt  = in_ack_after_read;
          shift_nxt       = '0;
          bit_count_nxt   = '0;
          scl_nxt         = 1'b0;
          phase_nxt       = imbe_pkg::PH_RL;
        end
        default: begin
        end
      endcase
    end
  end

  // Result fields reflect the state after this beat
  always_comb begin
    res.scl_level    = scl_nxt;
    res.sda_level    = sda_in_mode_nxt | sda_nxt;
    res.sda_released = sda_in_mode_nxt;
    res.busy_res     = phase_nxt != imbe_pkg::PH_IDLE;
    res.done_res     = done;
    res.ack_seen     = ack_result_nxt;
    res.timed_out    = timeout_flag_nxt;
    res.rx_byte      = rx_hold_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= imbe_pkg::HALF_PERIOD_RST;
      ack_timeout_r <= imbe_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        imbe_pkg::CFG_HALF_PERIOD: half_period_r <= cfg_wdata[15:0];
        imbe_pkg::CFG_ACK_TIMEOUT: ack_timeout_r <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Engine state advances only on an accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= imbe_pkg::PH_IDLE;
      bit_count_r    <= '0;
      shift_r        <= '0;
      tick_count_r   <= '0;
      poll_count_r   <= '0;
      scl_r          <= 1'b1;
      sda_r          <= 1'b1;
      sda_in_mode_r  <= 1'b0;
      ack_choice_r   <= 1'b0;
      ack_result_r   <= 1'b0;
      timeout_flag_r <= 1'b0;
      rx_hold_r      <= '0;
    end else if (in_accept) begin
      phase_r        <= phase_nxt;
      bit_count_r    <= bit_count_nxt;
      shift_r        <= shift_nxt;
      tick_count_r   <= tick_count_nxt;
      poll_count_r   <= poll_count_nxt;
      scl_r          <= scl_nxt;
      sda_r          <= sda_nxt;
      sda_in_mode_r  <= sda_in_mode_nxt;
      ack_choice_r   <= ack_choice_nxt;
      ack_result_r   <= ack_result_nxt;
      timeout_flag_r <= timeout_flag_nxt;
      rx_hold_r      <= rx_hold_nxt;
    end
  end

  // Result register: load on accept, drop on drain, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= {1'b0, res};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* design/imbe_checker.sv */
// ============================================================================
// imbe_checker - port-level checks of the I2C master byte engine
// Watches the result stream and its backpressure.
// ============================================================================
module imbe_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [imbe_pkg::OUT_DATA_W-1:0] out_tdata
);

  // A stalled result beat holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // With no result pending the engine always takes input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input stalled with a free result register");

  // A completing beat leaves the engine idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4] |-> !out_tdata[3])
    else $error("done reported while still busy");

  // A released SDA reads back high
  a_release_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[1])
    else $error("released SDA reported low");

  // Nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind i2c_master_byte_engine_unit imbe_checker u_imbe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_top - testbench of the I2C master byte engine unit
// Feeds command and tick beats through the input stream and checks every
// result beat against a cycle-free model of the bus sequencer kept here.
// A short table covers idle ticks, unused codes, ignored commands and the
// byte extremes. Random phases follow, each under its own register setting.
// ============================================================================
module tb_top;

  localparam int CNT_W    = 16;
  localparam int LIMIT    = 4_000_000;
  localparam int LAT_WAIT = 4;         // result register latency plus margin
  localparam int NROWS    = 18;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [imbe_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [imbe_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            cfg_we     = 1'b0;
  logic                            cfg_addr   = 1'b0;
  logic [imbe_pkg::CFG_DATA_W-1:0] cfg_wdata  = '0;

  i2c_master_byte_engine_unit #(
    .TICK_COUNTER_WIDTH(CNT_W)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    // [2:0] func, [10:3] tx_byte, [11] ack_after_read, [12] sda_sample, [15:13] zero
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    // [0] scl_level, [1] sda_level, [2] sda_released, [3] busy_res, [4] done_res,
    // [5] ack_seen, [6] timed_out, [14:7] rx_byte, [15] zero
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bus sequencer model: register copies and engine state, reset values
  // --------------------------------------------------------------------------
  logic [15:0]       hp_cfg      = imbe_pkg::HALF_PERIOD_RST;
  logic [7:0]        ato_cfg     = imbe_pkg::ACK_TIMEOUT_RST;
  imbe_pkg::phase_t  eng_phase   = imbe_pkg::PH_IDLE;
  logic [3:0]        eng_bits    = '0;
  logic [7:0]        eng_shift   = '0;
  logic [CNT_W-1:0]  eng_ticks   = '0;
  logic [7:0]        eng_polls   = '0;
  logic              eng_scl     = 1'b1;
  logic              eng_sda     = 1'b1;
  logic              eng_sda_in  = 1'b0;
  logic              eng_ack_sel = 1'b0;
  logic              eng_ack_got = 1'b0;
  logic              eng_timeout = 1'b0;
  logic [7:0]        eng_rx      = '0;

  imbe_pkg::result_t exp_status_q[$];   // expected result beats, oldest first
  int      fail_count  = 0;
  int      beat_no     = 0;
  int      poll_left   = 0;    // high acknowledge samples still to send
  bit      gaps_on     = 1'b1; // random idling on both streams

  // Drive SCL high with SDA low, then release SDA after one delay
  function automatic void launch_stop();
    eng_sda_in = 1'b0;
    eng_scl    = 1'b1;
    eng_sda    = 1'b0;
    eng_ticks  = '0;
    eng_phase  = imbe_pkg::PH_P1;
  endfunction

  // Put the next data bit on SDA (MSB first) and raise SCL
  function automatic void shift_out_bit();
    eng_sda   = eng_shift[7];
    eng_shift = {eng_shift[6:0], 1'b0};
    eng_scl   = 1'b1;
  endfunction

  // Advance the model by one input beat and return the line/status beat
  function automatic imbe_pkg::result_t bus_step(logic [2:0] op, logic [7:0] tx,
                                                 logic ack, logic sda);
    logic              done;
    logic              expired;
    int unsigned       per;
    int unsigned       lim;
    int unsigned       nxt;
    imbe_pkg::result_t r;
    done = 1'b0;
    if (op == imbe_pkg::FUNC_TICK) begin
      if (eng_phase == imbe_pkg::PH_POLL) begin
        // one acknowledge sample per tick, no delay counting
        if (!sda) begin
          eng_scl     = 1'b0;
          eng_ack_got = 1'b1;
          eng_phase   = imbe_pkg::PH_IDLE;
          done        = 1'b1;
        end else if ({1'b0, eng_polls} + 9'd1 > {1'b0, ato_cfg}) begin
          eng_ack_got = 1'b0;
          eng_timeout = 1'b1;
          launch_stop();
        end else begin
          eng_polls = eng_polls + 8'd1;
        end
      end else if (eng_phase != imbe_pkg::PH_IDLE) begin
        // zero half period counts as one; the counter width caps the delay
        lim = (32'd1 << CNT_W) - 32'd1;
        per = (hp_cfg == '0) ? 32'd1 : 32'(hp_cfg);
        if (per > lim) per = lim;
        nxt = 32'(eng_ticks) + 32'd1;
        if (nxt >= per) begin
          eng_ticks = '0;
          expired   = 1'b1;
        end else begin
          eng_ticks = nxt[CNT_W-1:0];
          expired   = 1'b0;
        end
        if (expired) begin
          case (eng_phase)
            imbe_pkg::PH_S1: begin
              eng_sda   = 1'b0;
              eng_phase = imbe_pkg::PH_S2;
            end
            imbe_pkg::PH_S2: begin
              eng_scl   = 1'b0;
              eng_phase = imbe_pkg::PH_IDLE;
              done      = 1'b1;
            end
            imbe_pkg::PH_P1: begin
              eng_sda   = 1'b1;
              eng_phase = imbe_pkg::PH_P2;
            end
            imbe_pkg::PH_P2: begin
              eng_phase = imbe_pkg::PH_IDLE;
              done      = 1'b1;
            end
            imbe_pkg::PH_WH: begin
              eng_scl   = 1'b0;
              eng_phase = imbe_pkg::PH_WL;
            end
            imbe_pkg::PH_WL: begin
              eng_bits = eng_bits + 4'd1;
              if (eng_bits >= 4'd8) begin
                eng_sda    = 1'b1;
                eng_sda_in = 1'b1;
                eng_phase  = imbe_pkg::PH_A1;
              end else begin
                shift_out_bit();
                eng_phase = imbe_pkg::PH_WH;
              end
            end
            imbe_pkg::PH_A1: begin
              eng_scl   = 1'b1;
              eng_phase = imbe_pkg::PH_A2;
            end
            imbe_pkg::PH_A2: begin
              eng_polls = '0;
              eng_phase = imbe_pkg::PH_POLL;
            end
            imbe_pkg::PH_RL: begin
              eng_scl   = 1'b1;
              eng_shift = {eng_shift[6:0], sda};
              eng_phase = imbe_pkg::PH_RH;
            end
            imbe_pkg::PH_RH: begin
              eng_bits = eng_bits + 4'd1;
              eng_scl  = 1'b0;
              if (eng_bits >= 4'd8) begin
                eng_rx     = eng_shift;
                eng_sda_in = 1'b0;
                eng_sda    = ~eng_ack_sel;
                eng_phase  = imbe_pkg::PH_M1;
              end else begin
                eng_phase = imbe_pkg::PH_RL;
              end
            end
            imbe_pkg::PH_M1: begin
              eng_scl   = 1'b1;
              eng_phase = imbe_pkg::PH_M2;
            end
            imbe_pkg::PH_M2: begin
              eng_scl   = 1'b0;
              eng_phase = imbe_pkg::PH_IDLE;
              done      = 1'b1;
            end
            default: eng_phase = imbe_pkg::PH_IDLE;
          endcase
        end
      end
    end else if (eng_phase == imbe_pkg::PH_IDLE) begin
      // commands are taken only while idle; unused codes just clear the counter
      eng_ticks = '0;
      case (op)
        imbe_pkg::FUNC_START: begin
          eng_sda_in = 1'b0;
          eng_sda    = 1'b1;
          eng_scl    = 1'b1;
          eng_phase  = imbe_pkg::PH_S1;
        end
        imbe_pkg::FUNC_STOP: launch_stop();
        imbe_pkg::FUNC_WRITE: begin
          eng_ack_got = 1'b0;
          eng_timeout = 1'b0;
          eng_sda_in  = 1'b0;
          eng_bits    = '0;
          eng_shift   = tx;
          shift_out_bit();
          eng_phase   = imbe_pkg::PH_WH;
        end
        imbe_pkg::FUNC_READ: begin
          eng_sda_in  = 1'b1;
          eng_ack_sel = ack;
          eng_shift   = '0;
          eng_bits    = '0;
          eng_scl     = 1'b0;
          eng_phase   = imbe_pkg::PH_RL;
        end
        default: ;
      endcase
    end
    r.scl_level    = eng_scl;
    r.sda_level    = eng_sda_in ? 1'b1 : eng_sda;
    r.sda_released = eng_sda_in;
    r.busy_res     = (eng_phase != imbe_pkg::PH_IDLE);
    r.done_res     = done;
    r.ack_seen     = eng_ack_got;
    r.timed_out    = eng_timeout;
    r.rx_byte      = eng_rx;
    return r;
  endfunction

  function automatic imbe_pkg::result_t mk_res(logic scl, logic sda, logic rel, logic busy,
                                               logic done, logic ack, logic tmo,
                                               logic [7:0] rx);
    imbe_pkg::result_t r;
    r.scl_level    = scl;
    r.sda_level    = sda;
    r.sda_released = rel;
    r.busy_res     = busy;
    r.done_res     = done;
    r.ack_seen     = ack;
    r.timed_out    = tmo;
    r.rx_byte      = rx;
    return r;
  endfunction

  // SDA level for the next tick: hold the acknowledge plan while polling
  function automatic logic pick_sda(logic rnd, logic lvl);
    if (!rnd) return lvl;
    if (eng_phase == imbe_pkg::PH_POLL) begin
      if (poll_left > 0) begin
        poll_left = poll_left - 1;
        return 1'b1;
      end
      return 1'b0;
    end
    return 1'($urandom);
  endfunction

  // --------------------------------------------------------------------------
  // Input stream: one beat per call, optional idle burst in front of it.
  // The beat stays valid until the handshake; the next call or hold_input
  // replaces or drops it at the following falling edge.
  // --------------------------------------------------------------------------
  task automatic send_beat(input logic [2:0] op, input logic [7:0] tx, input logic ack,
                           input logic sda, input logic fixed,
                           input imbe_pkg::result_t want);
    imbe_pkg::result_t r;
    int                gap;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, sda, ack, tx, op};
    do @(posedge clk); while (!in_tready);
    r = bus_step(op, tx, ack, sda);
    // table rows with a typed result are checked against it, the rest against the model
    exp_status_q.push_back(fixed ? want : r);
  endtask

  task automatic hold_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // Tick until the engine is idle again; ticks carry random command fields
  task automatic tick_until_idle(input logic rnd, input logic lvl);
    while (eng_phase != imbe_pkg::PH_IDLE)
      send_beat(imbe_pkg::FUNC_TICK, 8'($urandom), 1'($urandom), pick_sda(rnd, lvl),
                1'b0, '0);
  endtask

  // Register writes only with the engine idle and every result drained
  task automatic write_regs(input logic [15:0] hp, input logic [7:0] ato);
    hold_input();
    while (exp_status_q.size() != 0) @(posedge clk);
    repeat (LAT_WAIT) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= imbe_pkg::CFG_HALF_PERIOD;
    cfg_wdata <= hp;
    @(negedge clk);
    cfg_addr  <= imbe_pkg::CFG_ACK_TIMEOUT;
    cfg_wdata <= {8'($urandom), ato};   // upper byte is don't-care for this register
    @(negedge clk);
    cfg_we    <= 1'b0;
    hp_cfg  = hp;
    ato_cfg = ato;
  endtask

  // Mostly complete commands with random content, some ignored noise mixed in
  task automatic random_phase(input int n);
    int         useful;
    int         r;
    logic [2:0] op;
    useful = 0;
    while (useful < n) begin
      r = $urandom_range(0, 99);
      if (eng_phase == imbe_pkg::PH_IDLE) begin
        if (r < 8)       op = imbe_pkg::FUNC_TICK;
        else if (r < 12) op = imbe_pkg::FUNC_READ + 3'($urandom_range(1, 3));
        else             op = 3'($urandom_range(imbe_pkg::FUNC_START, imbe_pkg::FUNC_READ));
        if (op == imbe_pkg::FUNC_WRITE)
          poll_left = ($urandom_range(0, 4) == 0) ? int'(ato_cfg) + 1 : $urandom_range(0, 3);
        if (op >= imbe_pkg::FUNC_START && op <= imbe_pkg::FUNC_READ) useful++;
      end else begin
        op = (r < 5) ? 3'($urandom_range(imbe_pkg::FUNC_START, imbe_pkg::FUNC_READ + 3))
                     : imbe_pkg::FUNC_TICK;
        if (op == imbe_pkg::FUNC_TICK) useful++;
      end
      send_beat(op, 8'($urandom), 1'($urandom), pick_sda(1'b1, 1'b0), 1'b0, '0);
    end
    tick_until_idle(1'b1, 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // Directed table: op, tx, ack, sda (also held while settling), settle, typed
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic [2:0]        op;
    logic [7:0]        tx;
    logic              ack;
    logic              sda;
    logic              settle;
    logic              fixed;
    imbe_pkg::result_t want;
  } dir_row_t;

  dir_row_t dir_plan [NROWS];

  function automatic dir_row_t drow(logic [2:0] op, logic [7:0] tx, logic ack, logic sda,
                                    logic settle, logic fixed, imbe_pkg::result_t want);
    dir_row_t d;
    d.op     = op;
    d.tx     = tx;
    d.ack    = ack;
    d.sda    = sda;
    d.settle = settle;
    d.fixed  = fixed;
    d.want   = want;
    return d;
  endfunction

  initial begin
    imbe_pkg::result_t idle_r;
    imbe_pkg::result_t go_r;
    idle_r = mk_res(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
    go_r   = mk_res(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
    // idle ticks and unused codes leave the lines at reset level
    dir_plan[0]  = drow(imbe_pkg::FUNC_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, idle_r);
    dir_plan[1]  = drow(imbe_pkg::FUNC_TICK, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, idle_r);
    dir_plan[2]  = drow(imbe_pkg::FUNC_READ + 3'd1, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, idle_r);
    dir_plan[3]  = drow(imbe_pkg::FUNC_READ + 3'd2, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, idle_r);
    dir_plan[4]  = drow(imbe_pkg::FUNC_READ + 3'd3, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, idle_r);
    // start, then a write while busy that must be ignored
    dir_plan[5]  = drow(imbe_pkg::FUNC_START, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, go_r);
    dir_plan[6]  = drow(imbe_pkg::FUNC_WRITE, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, go_r);
    // all-ones byte acknowledged, all-zeros byte runs into the poll limit
    dir_plan[7]  = drow(imbe_pkg::FUNC_WRITE, 8'hFF, 1'b0, 1'b0, 1'b1, 1'b1, go_r);
    dir_plan[8]  = drow(imbe_pkg::FUNC_WRITE, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1,
                        mk_res(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
    // reads of all ones with ACK and all zeros with NACK
    dir_plan[9]  = drow(imbe_pkg::FUNC_READ, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1,
                        mk_res(1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 8'h00));
    dir_plan[10] = drow(imbe_pkg::FUNC_READ,  8'hFF, 1'b0, 1'b0, 1'b1, 1'b0, '0);
    dir_plan[11] = drow(imbe_pkg::FUNC_STOP,  8'h00, 1'b0, 1'b1, 1'b1, 1'b0, '0);
    dir_plan[12] = drow(imbe_pkg::FUNC_START, 8'hFF, 1'b1, 1'b0, 1'b1, 1'b0, '0);
    dir_plan[13] = drow(imbe_pkg::FUNC_WRITE, 8'hA5, 1'b0, 1'b0, 1'b1, 1'b0, '0);
    dir_plan[14] = drow(imbe_pkg::FUNC_READ,  8'h00, 1'b1, 1'b1, 1'b0, 1'b0, '0);
    dir_plan[15] = drow(imbe_pkg::FUNC_STOP,  8'h00, 1'b0, 1'b1, 1'b1, 1'b0, '0);
    dir_plan[16] = drow(imbe_pkg::FUNC_WRITE, 8'h5A, 1'b0, 1'b1, 1'b1, 1'b0, '0);
    dir_plan[17] = drow(imbe_pkg::FUNC_TICK,  8'h3C, 1'b1, 1'b0, 1'b0, 1'b0, '0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part with a short delay and poll limit so every command settles fast
    write_regs(16'd1, 8'd3);
    for (int i = 0; i < NROWS; i++) begin
      send_beat(dir_plan[i].op, dir_plan[i].tx, dir_plan[i].ack, dir_plan[i].sda,
                dir_plan[i].fixed, dir_plan[i].want);
      if (dir_plan[i].settle) tick_until_idle(1'b0, dir_plan[i].sda);
    end

    // random phases: shortest delay with zero poll limit, zero delay with longest limit
    write_regs(16'd1, 8'd0);
    random_phase(170);
    write_regs(16'd0, 8'd255);
    random_phase(170);
    write_regs(16'd3, 8'd1);
    random_phase(170);
    write_regs(16'd2, 8'd20);
    random_phase(170);

    // last stretch runs without idling on either stream
    gaps_on = 1'b0;
    write_regs(16'd1, 8'd3);
    random_phase(200);

    hold_input();
    while (exp_status_q.size() != 0) @(posedge clk);
    repeat (LAT_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("i2c_master_byte_engine_unit test passed");
    end else begin
      $display("i2c_master_byte_engine_unit test failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result stream: random stall bursts while idling is on
  // --------------------------------------------------------------------------
  int   rdy_left = 0;
  logic rdy_mode = 1'b1;

  always @(negedge clk) begin
    if (rdy_left == 0) begin
      rdy_mode = !(gaps_on && $urandom_range(0, 4) == 0);
      rdy_left = rdy_mode ? $urandom_range(1, 16) : $urandom_range(1, 13);
    end
    rdy_left = rdy_left - 1;
    out_tready <= rdy_mode;
  end

  // --------------------------------------------------------------------------
  // Check each accepted result beat against the oldest expectation
  // --------------------------------------------------------------------------
  imbe_pkg::result_t chk_want;
  imbe_pkg::result_t chk_got;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      chk_got = imbe_pkg::result_t'(out_tdata[14:0]);
      if (exp_status_q.size() == 0) begin
        if (fail_count < 10)
          $display("beat %0d: result with nothing expected, data %h", beat_no, out_tdata);
        fail_count++;
      end else begin
        chk_want = exp_status_q.pop_front();
        if (chk_got.scl_level    !== chk_want.scl_level    ||
            chk_got.sda_level    !== chk_want.sda_level    ||
            chk_got.sda_released !== chk_want.sda_released ||
            chk_got.busy_res     !== chk_want.busy_res     ||
            chk_got.done_res     !== chk_want.done_res     ||
            chk_got.ack_seen     !== chk_want.ack_seen     ||
            chk_got.timed_out    !== chk_want.timed_out    ||
            chk_got.rx_byte      !== chk_want.rx_byte      ||
            out_tdata[15]        !== 1'b0) begin
          if (fail_count < 10)
            $display("beat %0d: scl/sda/rel/busy/done/ack/tmo/rx expected %b %b %b %b %b %b %b %h",
                     beat_no,
                     chk_want.scl_level, chk_want.sda_level, chk_want.sda_released,
                     chk_want.busy_res, chk_want.done_res, chk_want.ack_seen,
                     chk_want.timed_out, chk_want.rx_byte,
                     ", got %b %b %b %b %b %b %b %h (pad %b)",
                     chk_got.scl_level, chk_got.sda_level, chk_got.sda_released,
                     chk_got.busy_res, chk_got.done_res, chk_got.ack_seen,
                     chk_got.timed_out, chk_got.rx_byte, out_tdata[15]);
          fail_count++;
        end
      end
      beat_no++;
    end
  end

  // Watchdog: the slowest correct run stays well below this
  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("i2c_master_byte_engine_unit test failed");
      $finish;
    end
  end

endmodule
